// ===== sv/rsd_pkg.sv =====
// Shared types and constants for the descending record sorter.
// No dependencies; used by rsd_store, rsd_sorter and record_sort_descending.
`default_nettype none

package rsd_pkg;

    localparam int KEY_W   = 16;
    localparam int TAG_W   = 31;
    localparam int TDATA_W = 48;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [KEY_W-1:0] key;
    } rec_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic done;
    } srt_stat_t;

    typedef enum logic [1:0] {
        SRT_IDLE,
        SRT_ROW_CAP,
        SRT_CMP,
        SRT_ROW_WR
    } srt_state_t;

    typedef enum logic [2:0] {
        TOP_LOAD,
        TOP_SORT,
        TOP_EMIT_RD,
        TOP_EMIT_CAP,
        TOP_EMIT_WAIT
    } top_state_t;

endpackage

`default_nettype wire

// ===== sv/record_sort_descending.sv =====
// Loading accepts one item per cycle in the load state; after the last item the sort
// runs one row for each of the first n-1 positions (n records), then each result is
// read through the store read port into the output register and held until taken.
// Speed is set by the single shared comparator and the single read port of the store.
// Reset: synchronous, active low; control state cleared, store contents undefined.
`default_nettype none

module record_sort_descending #(
    parameter int DEPTH = 64
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire  [rsd_pkg::TDATA_W-1:0]      s_tdata,   // record_key[15:0], record_tag[46:16]
    input  wire                              s_tlast,   // last_record
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [rsd_pkg::TDATA_W-1:0]      m_tdata,   // sorted_key[15:0], sorted_tag[46:16]
    output logic                             m_tlast,   // final_result
    output logic [0:0]                       m_tuser    // records_dropped
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    rsd_pkg::top_state_t state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                ovf_reg, ovf_next;
    logic [AW-1:0]       k_reg, k_next;
    rsd_pkg::rec_t       out_rec_reg, out_rec_next;
    logic                out_last_reg, out_last_next;
    logic                out_drop_reg, out_drop_next;

    logic               load_acc;
    logic               full;
    logic [CW-1:0]      n_eff;
    logic               start;
    logic               emit_last;

    logic               st_wr_en, st_rd_en;
    logic [AW-1:0]      st_wr_addr, st_rd_addr;
    rsd_pkg::rec_t      st_wr_data, st_rd_data;
    rsd_pkg::rec_t      in_rec;

    logic [AW-1:0]      srt_rd_addr, srt_wr_addr;
    rsd_pkg::rec_t      srt_wr_data;
    rsd_pkg::srt_stat_t srt_stat;

    assign in_rec.key = s_tdata[rsd_pkg::KEY_W-1:0];
    assign in_rec.tag = s_tdata[rsd_pkg::KEY_W+rsd_pkg::TAG_W-1:rsd_pkg::KEY_W];

    assign full      = count_reg == CW'(DEPTH);
    assign load_acc  = s_tvalid && (state_reg == rsd_pkg::TOP_LOAD);
    assign n_eff     = full ? count_reg : count_reg + CW'(1);
    assign start     = load_acc && s_tlast && (n_eff >= CW'(2));
    assign emit_last = CW'(k_reg) == (count_reg - CW'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rsd_pkg::TOP_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            k_reg     <= k_next;
        end
        out_rec_reg  <= out_rec_next;
        out_last_reg <= out_last_next;
        out_drop_reg <= out_drop_next;
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        k_next        = k_reg;
        out_rec_next  = out_rec_reg;
        out_last_next = out_last_reg;
        out_drop_next = out_drop_reg;
        case (state_reg)
            rsd_pkg::TOP_LOAD: begin
                if (load_acc) begin
                    if (full) begin
                        ovf_next = 1'b1;
                    end else begin
                        count_next = count_reg + CW'(1);
                    end
                    if (s_tlast) begin
                        k_next = '0;
                        if (start) begin
                            state_next = rsd_pkg::TOP_SORT;
                        end else begin
                            state_next = rsd_pkg::TOP_EMIT_RD;
                        end
                    end
                end
            end
            rsd_pkg::TOP_SORT: begin
                if (srt_stat.done) begin
                    state_next = rsd_pkg::TOP_EMIT_RD;
                end
            end
            rsd_pkg::TOP_EMIT_RD: begin
                state_next = rsd_pkg::TOP_EMIT_CAP;
            end
            rsd_pkg::TOP_EMIT_CAP: begin
                out_rec_next  = st_rd_data;
                out_last_next = emit_last;
                out_drop_next = ovf_reg;
                state_next    = rsd_pkg::TOP_EMIT_WAIT;
            end
            rsd_pkg::TOP_EMIT_WAIT: begin
                if (m_tready) begin
                    if (out_last_reg) begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = rsd_pkg::TOP_LOAD;
                    end else begin
                        k_next     = k_reg + AW'(1);
                        state_next = rsd_pkg::TOP_EMIT_CAP;
                    end
                end
            end
            default: begin
                state_next = rsd_pkg::TOP_LOAD;
            end
        endcase
    end

    always_comb begin
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        st_wr_en   = 1'b0;
        st_wr_addr = count_reg[AW-1:0];
        st_wr_data = in_rec;
        st_rd_en   = 1'b0;
        st_rd_addr = k_reg;
        case (state_reg)
            rsd_pkg::TOP_LOAD: begin
                s_tready   = 1'b1;
                st_wr_en   = load_acc && !full;
                st_rd_en   = srt_stat.rd_en;
                st_rd_addr = srt_rd_addr;
            end
            rsd_pkg::TOP_SORT: begin
                st_wr_en   = srt_stat.wr_en;
                st_wr_addr = srt_wr_addr;
                st_wr_data = srt_wr_data;
                st_rd_en   = srt_stat.rd_en;
                st_rd_addr = srt_rd_addr;
            end
            rsd_pkg::TOP_EMIT_RD: begin
                st_rd_en = 1'b1;
            end
            rsd_pkg::TOP_EMIT_CAP: begin
                st_rd_en = 1'b0;
            end
            rsd_pkg::TOP_EMIT_WAIT: begin
                m_tvalid   = 1'b1;
                st_rd_en   = m_tready && !out_last_reg;
                st_rd_addr = k_reg + AW'(1);
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign m_tdata = {{(rsd_pkg::TDATA_W-rsd_pkg::KEY_W-rsd_pkg::TAG_W){1'b0}},
                      out_rec_reg.tag, out_rec_reg.key};
    assign m_tlast = out_last_reg;
    assign m_tuser = out_drop_reg;

    rsd_sorter #(
        .DEPTH(DEPTH)
    ) u_sorter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start_i   (start),
        .n_i       (count_reg),
        .rd_data_i (st_rd_data),
        .rd_addr_o (srt_rd_addr),
        .wr_addr_o (srt_wr_addr),
        .wr_data_o (srt_wr_data),
        .stat_o    (srt_stat)
    );

    rsd_store #(
        .DEPTH(DEPTH)
    ) u_store (
        .aclk      (aclk),
        .wr_en_i   (st_wr_en),
        .wr_addr_i (st_wr_addr),
        .wr_data_i (st_wr_data),
        .rd_en_i   (st_rd_en),
        .rd_addr_i (st_rd_addr),
        .rd_data_o (st_rd_data)
    );

endmodule

`default_nettype wire

// ===== sv/rsd_store.sv =====
// Record store: one write port, one read port with registered read data.
// Depends on rsd_pkg for the record type.
`default_nettype none

module rsd_store #(
    parameter int DEPTH = 64
) (
    input  wire                          aclk,
    input  wire                          wr_en_i,
    input  wire  [$clog2(DEPTH)-1:0]     wr_addr_i,
    input  rsd_pkg::rec_t                wr_data_i,
    input  wire                          rd_en_i,
    input  wire  [$clog2(DEPTH)-1:0]     rd_addr_i,
    output rsd_pkg::rec_t                rd_data_o
);

    rsd_pkg::rec_t mem [DEPTH];
    rsd_pkg::rec_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en_i) begin
            mem[wr_addr_i] <= wr_data_i;
        end
        if (rd_en_i) begin
            rd_data_reg <= mem[rd_addr_i];
        end
    end

    assign rd_data_o = rd_data_reg;

endmodule

`default_nettype wire

// ===== sv/rsd_sorter.sv =====
// Exchange sort sequencer with a single key comparator; position i is held in a register.
// Depends on rsd_pkg; drives the ports of rsd_store through the top level.
`default_nettype none

module rsd_sorter #(
    parameter int DEPTH = 64
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              start_i,
    input  wire  [$clog2(DEPTH+1)-1:0]       n_i,
    input  rsd_pkg::rec_t                    rd_data_i,
    output logic [$clog2(DEPTH)-1:0]         rd_addr_o,
    output logic [$clog2(DEPTH)-1:0]         wr_addr_o,
    output rsd_pkg::rec_t                    wr_data_o,
    output rsd_pkg::srt_stat_t               stat_o
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    rsd_pkg::srt_state_t state_reg, state_next;
    logic [AW-1:0]       i_reg, i_next;
    logic [AW-1:0]       j_reg, j_next;
    rsd_pkg::rec_t       cur_reg, cur_next;

    logic [CW-1:0] nm1;
    logic          swap;
    logic          last_j;
    logic          more_rows;

    assign nm1       = n_i - CW'(1);
    assign swap      = cur_reg.key < rd_data_i.key;
    assign last_j    = CW'(j_reg) == nm1;
    assign more_rows = (CW'(i_reg) + CW'(1)) < nm1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rsd_pkg::SRT_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
        cur_reg <= cur_next;
    end

    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        cur_next   = cur_reg;
        case (state_reg)
            rsd_pkg::SRT_IDLE: begin
                if (start_i) begin
                    i_next     = '0;
                    state_next = rsd_pkg::SRT_ROW_CAP;
                end
            end
            rsd_pkg::SRT_ROW_CAP: begin
                cur_next   = rd_data_i;
                j_next     = i_reg + AW'(1);
                state_next = rsd_pkg::SRT_CMP;
            end
            rsd_pkg::SRT_CMP: begin
                if (swap) begin
                    cur_next = rd_data_i;
                end
                if (last_j) begin
                    state_next = rsd_pkg::SRT_ROW_WR;
                end else begin
                    j_next = j_reg + AW'(1);
                end
            end
            rsd_pkg::SRT_ROW_WR: begin
                i_next = i_reg + AW'(1);
                if (more_rows) begin
                    state_next = rsd_pkg::SRT_ROW_CAP;
                end else begin
                    state_next = rsd_pkg::SRT_IDLE;
                end
            end
            default: begin
                state_next = rsd_pkg::SRT_IDLE;
            end
        endcase
    end

    always_comb begin
        stat_o    = '0;
        rd_addr_o = i_reg;
        wr_addr_o = j_reg;
        wr_data_o = cur_reg;
        case (state_reg)
            rsd_pkg::SRT_IDLE: begin
                stat_o.rd_en = start_i;
                rd_addr_o    = '0;
            end
            rsd_pkg::SRT_ROW_CAP: begin
                stat_o.rd_en = 1'b1;
                rd_addr_o    = i_reg + AW'(1);
            end
            rsd_pkg::SRT_CMP: begin
                stat_o.wr_en = swap;
                stat_o.rd_en = !last_j;
                rd_addr_o    = j_reg + AW'(1);
            end
            rsd_pkg::SRT_ROW_WR: begin
                stat_o.wr_en = 1'b1;
                wr_addr_o    = i_reg;
                stat_o.rd_en = more_rows;
                rd_addr_o    = i_reg + AW'(1);
                stat_o.done  = !more_rows;
            end
            default: begin
                stat_o = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== bench/record_sort_descending_tb.sv =====
// Self-checking bench for record_sort_descending: directed and random runs of key/tag items,
// descending exchange-sort prediction and per-field checks on every result item.
// Depends on rsd_pkg and the record_sort_descending RTL only.
`timescale 1ns / 100ps

module record_sort_descending_tb;

    localparam int KEY_W       = rsd_pkg::KEY_W;
    localparam int TAG_W       = rsd_pkg::TAG_W;
    localparam int TDATA_W     = rsd_pkg::TDATA_W;
    localparam int DEPTH       = 64;
    localparam int KEY_MAX     = 40960;
    localparam int GAP_MAX     = 12;
    localparam int STALL_LIMIT = 20000;
    localparam int TAIL_CYCLES = 40;
    localparam int ITEM_BUDGET = 430;

    typedef enum int {
        KEYS_GRADE,
        KEYS_RAW,
        KEYS_TIED
    } key_mix_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        logic             final_rec;
        logic             dropped;
    } sorted_rec_t;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata  = '0;
    logic               s_tlast  = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tlast;
    logic [0:0]         m_tuser;

    logic [KEY_W-1:0] run_key [DEPTH];
    logic [TAG_W-1:0] run_tag [DEPTH];
    int               run_count    = 0;
    bit               run_dropped  = 1'b0;
    sorted_rec_t      sorted_due[$];
    sorted_rec_t      want;

    bit idle_on       = 1'b1;
    int err_count     = 0;
    int items_sent    = 0;
    int runs_closed   = 0;
    int runs_overflow = 0;
    int results_seen  = 0;
    int quiet         = 0;

    record_sort_descending #(
        .DEPTH(DEPTH)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // exchange sort of the run held so far, highest key first
    function automatic void rank_run();
        int               i;
        int               j;
        logic [KEY_W-1:0] k;
        logic [TAG_W-1:0] t;
        sorted_rec_t      r;
        for (i = 0; i + 1 < run_count; i++) begin
            for (j = i + 1; j < run_count; j++) begin
                if (run_key[i] < run_key[j]) begin
                    k          = run_key[i];
                    t          = run_tag[i];
                    run_key[i] = run_key[j];
                    run_tag[i] = run_tag[j];
                    run_key[j] = k;
                    run_tag[j] = t;
                end
            end
        end
        for (i = 0; i < run_count; i++) begin
            r.key       = run_key[i];
            r.tag       = run_tag[i];
            r.final_rec = (i + 1 == run_count);
            r.dropped   = run_dropped;
            sorted_due.push_back(r);
        end
        runs_closed++;
        if (run_dropped) begin
            runs_overflow++;
        end
        run_count   = 0;
        run_dropped = 1'b0;
    endfunction

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            items_sent++;
            if (run_count < DEPTH) begin
                run_key[run_count] = s_tdata[KEY_W-1:0];
                run_tag[run_count] = s_tdata[KEY_W +: TAG_W];
                run_count++;
            end else begin
                run_dropped = 1'b1;
            end
            if (s_tlast) begin
                rank_run();
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (sorted_due.size() == 0) begin
                $error("result item with none pending: tdata %h tlast %b", m_tdata, m_tlast);
                err_count++;
            end else begin
                want = sorted_due.pop_front();
                if (m_tdata[KEY_W-1:0] !== want.key) begin
                    $error("sorted_key: expected %h, got %h", want.key, m_tdata[KEY_W-1:0]);
                    err_count++;
                end
                if (m_tdata[KEY_W +: TAG_W] !== want.tag) begin
                    $error("sorted_tag: expected %h, got %h", want.tag,
                           m_tdata[KEY_W +: TAG_W]);
                    err_count++;
                end
                if (m_tlast !== want.final_rec) begin
                    $error("final_result: expected %b, got %b", want.final_rec, m_tlast);
                    err_count++;
                end
                if (m_tuser[0] !== want.dropped) begin
                    $error("records_dropped: expected %b, got %b", want.dropped, m_tuser[0]);
                    err_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("record_sort_descending_tb failed");
                $finish;
            end
        end
    end

    // result side back-pressure, redrawn per item
    initial begin
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = idle_on ? $urandom_range(GAP_MAX, 0) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    task automatic send_record(input logic [KEY_W-1:0] key, input logic [TAG_W-1:0] tag,
                               input bit last);
        int gap;
        gap = idle_on ? $urandom_range(GAP_MAX, 0) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, tag, key};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key(input key_mix_t mix);
        logic [KEY_W-1:0] k;
        case (mix)
            KEYS_RAW:  k = 16'($urandom_range(16'hFFFF, 0));
            KEYS_TIED: k = 16'($urandom_range(3, 0) * 10240);
            default:   k = 16'($urandom_range(KEY_MAX, 0));
        endcase
        return k;
    endfunction

    function automatic logic [TAG_W-1:0] pick_tag();
        logic [TAG_W-1:0] t;
        case ($urandom_range(15, 0))
            0:       t = '0;
            1:       t = '1;
            default: t = 31'($urandom);
        endcase
        return t;
    endfunction

    task automatic send_run(input int len, input key_mix_t mix);
        int i;
        for (i = 0; i < len; i++) begin
            send_record(pick_key(mix), pick_tag(), i == len - 1);
        end
    endtask

    task automatic test_single_records();
        send_record(16'd0, 31'd1, 1'b1);
        send_record(KEY_MAX[KEY_W-1:0], 31'h7FFF_FFFF, 1'b1);
        send_record(16'hFFFF, 31'd0, 1'b1);
        send_record(16'h8000, 31'h4000_0000, 1'b1);
    endtask

    task automatic test_extreme_keys();
        send_record(16'd0, 31'h0000_0011, 1'b0);
        send_record(KEY_MAX[KEY_W-1:0], 31'h5555_5555, 1'b0);
        send_record(16'hFFFF, 31'h2AAA_AAAA, 1'b0);
        send_record(16'd1, 31'h7FFF_FFFF, 1'b0);
        send_record(16'h7FFF, 31'h0000_0001, 1'b0);
        send_record(16'h8000, 31'h1234_5678, 1'b1);
    endtask

    // equal keys: exchange sort order for ties
    task automatic test_tied_keys();
        int vals [8] = '{5, 5, 9, 5, 9, 0, 9, 5};
        int i;
        for (i = 0; i < 8; i++) begin
            send_record(16'(vals[i] * 4096), 31'(i + 1), i == 7);
        end
    endtask

    task automatic test_pairs();
        send_record(16'd100, 31'd21, 1'b0);
        send_record(16'd200, 31'd22, 1'b1);
        send_record(16'd200, 31'd23, 1'b0);
        send_record(16'd100, 31'd24, 1'b1);
    endtask

    task automatic test_full_store();
        idle_on = 1'b0;
        send_run(DEPTH, KEYS_GRADE);
        idle_on = 1'b1;
    endtask

    // store full: extra items dropped, last one still closes the run
    task automatic test_overflow();
        send_run(DEPTH + 1, KEYS_TIED);
        send_run(DEPTH + 3, KEYS_RAW);
    endtask

    task automatic test_random_runs();
        int       len;
        key_mix_t mix;
        while (items_sent < ITEM_BUDGET) begin
            idle_on = ($urandom_range(3, 0) != 0);
            len = ($urandom_range(9, 0) == 0) ? $urandom_range(DEPTH + 4, 30)
                                              : $urandom_range(12, 1);
            mix = key_mix_t'($urandom_range(2, 0));
            send_run(len, mix);
        end
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_single_records();
        test_extreme_keys();
        test_tied_keys();
        test_pairs();
        test_full_store();
        test_overflow();
        test_random_runs();

        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        @(posedge aclk);
        while (sorted_due.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("%0d items in %0d runs (%0d with dropped records), %0d result items checked",
                 items_sent, runs_closed, runs_overflow, results_seen);
        if (err_count == 0) begin
            $display("record_sort_descending_tb passed");
        end else begin
            $display("record_sort_descending_tb failed");
        end
        $finish;
    end

endmodule
